// File: rtl/abht_pkg.sv
package abht_pkg;

    // Mask geometry; the row stride is MAX_WIDTH, so both must be powers of two
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CELL_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int MASK_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    // Field widths
    localparam int ALPHA_W = 8;
    localparam int POINT_W = 20;
    localparam int SCALE_W = 16;
    localparam int SIZE_W  = 9;

    // Size arithmetic width: holds the register value and MAX_WIDTH / MAX_HEIGHT
    localparam int DIM_A_W = CELL_W + 1;
    localparam int DIM_W   = (DIM_A_W > SIZE_W) ? DIM_A_W : SIZE_W;

    // Mapping arithmetic: Q.4 difference times Q8.8 scale gives Q.12
    localparam int DIFF_W = POINT_W + 1;
    localparam int PROD_W = DIFF_W + SCALE_W + 1;
    localparam int FRAC_W = 12;
    localparam int HI_W   = PROD_W - FRAC_W;

    localparam logic [ALPHA_W-1:0] ALPHA_LIMIT = 8'd127;

    // Stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_INV_SCALE_X  = 3'd2,
        REG_INV_SCALE_Y  = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5
    } cfg_reg_t;

    // Input kind carried in tuser
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // Mask write request from the loader
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } mask_wr_t;

    // Size register value forced into 1..most
    function automatic logic [DIM_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [DIM_W-1:0] most);
        logic [DIM_W-1:0] ext;
        ext = DIM_W'(v);
        if (ext == '0)
            return DIM_W'(1);
        else if (ext > most)
            return most;
        else
            return ext;
    endfunction

endpackage

// File: rtl/alpha_bitmask_hit_test.sv
// Alpha bitmask hit test.
// Input stream: s_tuser[0] selects the beat kind, load (0) or query (1).
// A load beat carries an alpha byte of the next raster pixel; until the image is
// loaded it is thresholded and stored as one mask bit; it returns nothing. A query
// beat carries a Q16.4 point and returns one beat on the output stream with
// is_masked in m_tdata[0]: 1 before the full image is loaded, else the mask
// bit at the mapped cell, 0 outside the image.
// A query result passes the input register, the multiplier register and the
// mask read register before it is presented on the output stream.
// Throughput: one beat per cycle while the output does not stall, set by the
// registered multiply per axis and the one read port of the mask memory.
// The configuration channel is always ready; write it while the block idles.
// Reset clears the load position and the loaded flag and restores the
// default registers; the mask memory itself is not cleared.
// When the output stalls the whole pipeline holds and s_tready drops while a
// result is waiting and m_tready is low.
module alpha_bitmask_hit_test (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // alpha[7:0], point_x[27:8], point_y[47:28]
    input  logic [abht_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                       s_tuser,   // op[0]
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [abht_pkg::OUT_TDATA_W-1:0] m_tdata,   // is_masked[0], zero[7:1]
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [abht_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [abht_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic signed [abht_pkg::POINT_W-1:0] origin_x_reg, origin_y_reg;
    logic [abht_pkg::SCALE_W-1:0]        inv_scale_x_reg, inv_scale_y_reg;
    logic [abht_pkg::SIZE_W-1:0]         image_width_reg, image_height_reg;

    // Pipeline
    logic                                advance;
    logic                                in_valid_reg, in_valid_next;
    logic                                in_op_reg;
    logic [abht_pkg::ALPHA_W-1:0]        alpha_reg;
    logic signed [abht_pkg::POINT_W-1:0] point_x_reg, point_y_reg;
    logic                                q2_valid_reg, q2_valid_next;
    logic                                q2_loaded_reg;
    logic                                q3_valid_reg, q3_valid_next;
    logic                                q3_force_reg, q3_inside_reg;

    logic [abht_pkg::DIM_W-1:0]          width_c, height_c;
    abht_pkg::mask_wr_t                  wr;
    logic                                loaded;
    logic                                inside_x, inside_y;
    logic [abht_pkg::CELL_W-1:0]         cell_x, cell_y;
    logic [abht_pkg::ADDR_W-1:0]         rd_addr;
    logic                                rd_data;

    assign cfg_ready = 1'b1;
    assign advance   = !q3_valid_reg || m_tready;
    assign s_tready  = advance;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            inv_scale_x_reg  <= abht_pkg::SCALE_W'(256);
            inv_scale_y_reg  <= abht_pkg::SCALE_W'(256);
            image_width_reg  <= abht_pkg::SIZE_W'(256);
            image_height_reg <= abht_pkg::SIZE_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (abht_pkg::cfg_reg_t'(cfg_index))
                abht_pkg::REG_ORIGIN_X:     origin_x_reg     <= cfg_data[abht_pkg::POINT_W-1:0];
                abht_pkg::REG_ORIGIN_Y:     origin_y_reg     <= cfg_data[abht_pkg::POINT_W-1:0];
                abht_pkg::REG_INV_SCALE_X:  inv_scale_x_reg  <= cfg_data[abht_pkg::SCALE_W-1:0];
                abht_pkg::REG_INV_SCALE_Y:  inv_scale_y_reg  <= cfg_data[abht_pkg::SCALE_W-1:0];
                abht_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[abht_pkg::SIZE_W-1:0];
                abht_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[abht_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign width_c  = abht_pkg::clamp_size(image_width_reg,
                                           abht_pkg::DIM_W'(abht_pkg::MAX_WIDTH));
    assign height_c = abht_pkg::clamp_size(image_height_reg,
                                           abht_pkg::DIM_W'(abht_pkg::MAX_HEIGHT));

    // Valid chain; loads leave after the input stage
    assign in_valid_next = s_tvalid;
    assign q2_valid_next = in_valid_reg && (in_op_reg == abht_pkg::OP_QUERY);
    assign q3_valid_next = q2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            q2_valid_reg <= 1'b0;
            q3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= in_valid_next;
            q2_valid_reg <= q2_valid_next;
            q3_valid_reg <= q3_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_op_reg     <= s_tuser[0];
            alpha_reg     <= s_tdata[7:0];
            point_x_reg   <= s_tdata[27:8];
            point_y_reg   <= s_tdata[47:28];
            q2_loaded_reg <= loaded;
            q3_force_reg  <= !q2_loaded_reg;
            q3_inside_reg <= inside_x && inside_y;
        end
    end

    // Raster loader
    abht_loader u_loader (
        .clk     (clk),
        .rst_n   (rst_n),
        .load_en (advance && in_valid_reg && (in_op_reg == abht_pkg::OP_LOAD)),
        .alpha   (alpha_reg),
        .width   (width_c),
        .height  (height_c),
        .wr      (wr),
        .loaded  (loaded)
    );

    // Point to cell mapping, one unit per axis
    abht_axis_map u_map_x (
        .clk       (clk),
        .en        (advance),
        .point     (point_x_reg),
        .origin    (origin_x_reg),
        .inv_scale (inv_scale_x_reg),
        .size      (width_c),
        .in_range  (inside_x),
        .cell_idx  (cell_x)
    );

    abht_axis_map u_map_y (
        .clk       (clk),
        .en        (advance),
        .point     (point_y_reg),
        .origin    (origin_y_reg),
        .inv_scale (inv_scale_y_reg),
        .size      (height_c),
        .in_range  (inside_y),
        .cell_idx  (cell_y)
    );

    assign rd_addr = {cell_y[abht_pkg::ROW_W-1:0], cell_x[abht_pkg::COL_W-1:0]};

    abht_mask_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (advance),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result beat
    assign m_tvalid = q3_valid_reg;
    assign m_tdata  = {(abht_pkg::OUT_TDATA_W - 1)'(0),
                       q3_force_reg || (q3_inside_reg && rd_data)};

endmodule

// File: rtl/abht_mask_mem.sv
module abht_mask_mem (
    input  logic                     clk,
    input  abht_pkg::mask_wr_t       wr,
    input  logic                     rd_en,
    input  logic [abht_pkg::ADDR_W-1:0] rd_addr,
    output logic                     rd_data
);

    logic mask_mem [abht_pkg::MASK_DEPTH];
    logic rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mask_mem[wr.addr] <= wr.data;
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mask_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/abht_loader.sv
module abht_loader (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load_en,
    input  logic [abht_pkg::ALPHA_W-1:0] alpha,
    input  logic [abht_pkg::DIM_W-1:0]   width,
    input  logic [abht_pkg::DIM_W-1:0]   height,
    output abht_pkg::mask_wr_t           wr,
    output logic                         loaded
);

    logic [abht_pkg::COL_W-1:0] col_reg, col_next;
    logic [abht_pkg::ROW_W:0]   row_reg, row_next;
    logic                       loaded_reg, loaded_next;
    logic [abht_pkg::DIM_W-1:0] col_inc;
    logic                       take;

    assign take    = load_en && !loaded_reg;
    assign col_inc = abht_pkg::DIM_W'(col_reg) + abht_pkg::DIM_W'(1);

    // Raster position advance and write request
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        loaded_next = loaded_reg;
        wr.en       = take && (row_reg < (abht_pkg::ROW_W + 1)'(abht_pkg::MAX_HEIGHT));
        wr.addr     = {row_reg[abht_pkg::ROW_W-1:0], col_reg};
        wr.data     = (alpha > abht_pkg::ALPHA_LIMIT);
        if (take)
        begin
            if (col_inc >= width)
            begin
                col_next = '0;
                row_next = row_reg + (abht_pkg::ROW_W + 1)'(1);
                if (abht_pkg::DIM_W'(row_next) >= height)
                    loaded_next = 1'b1;
            end
            else
            begin
                col_next = col_inc[abht_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            loaded_reg <= loaded_next;
        end
    end

    assign loaded = loaded_reg;

endmodule

// File: rtl/abht_axis_map.sv
module abht_axis_map (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [abht_pkg::POINT_W-1:0] point,
    input  logic signed [abht_pkg::POINT_W-1:0] origin,
    input  logic [abht_pkg::SCALE_W-1:0]        inv_scale,
    input  logic [abht_pkg::DIM_W-1:0]          size,
    output logic                                in_range,
    output logic [abht_pkg::CELL_W-1:0]         cell_idx
);

    logic signed [abht_pkg::DIFF_W-1:0] diff;
    logic signed [abht_pkg::PROD_W-1:0] prod_next, prod_reg;
    logic [abht_pkg::HI_W-1:0]          cell_full;

    // Offset from origin times inverse scale, Q.12 result
    assign diff      = abht_pkg::DIFF_W'(point) - abht_pkg::DIFF_W'(origin);
    assign prod_next = diff * $signed({1'b0, inv_scale});

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= prod_next;
    end

    // Floor to a cell, negative products are outside
    assign cell_full = prod_reg[abht_pkg::PROD_W-1:abht_pkg::FRAC_W];
    assign in_range  = !prod_reg[abht_pkg::PROD_W-1] &&
                       (cell_full < abht_pkg::HI_W'(size));
    assign cell_idx  = prod_reg[abht_pkg::FRAC_W +: abht_pkg::CELL_W];

endmodule

// File: rtl/abht_checker.sv
module abht_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [0:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [abht_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic q_beat, flow;

    assign q_beat = s_tvalid && s_tready && (s_tuser[0] == abht_pkg::OP_QUERY);
    assign flow   = !m_tvalid || m_tready;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Input only waits on a stalled result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready with empty output");

    // A query reaches the output when the result side keeps flowing after it
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        q_beat ##1 flow ##1 flow |=> m_tvalid)
        else $error("query result missing");

endmodule

bind alpha_bitmask_hit_test abht_checker u_abht_checker (.*);

// File: tb/tb_alpha_bitmask_hit_test.sv
`timescale 1ns / 1ps

module tb_alpha_bitmask_hit_test;
    import abht_pkg::*;

    localparam int IDLE_LIMIT  = 5000;   // cycles with no beat on any channel
    localparam int HOLD_AT     = 400;    // results seen before the long output hold
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 6;      // pipeline depth plus margin

    // Expected hit bits and a private copy of the mask, load cursor and registers
    class mask_scoreboard;
        bit                 mask_mem [MASK_DEPTH];
        bit                 written  [MASK_DEPTH];
        int unsigned        load_col = 0;
        int unsigned        load_row = 0;
        bit                 loaded = 1'b0;
        logic [POINT_W-1:0] org_x = '0;
        logic [POINT_W-1:0] org_y = '0;
        logic [SCALE_W-1:0] inv_x = 16'd256;
        logic [SCALE_W-1:0] inv_y = 16'd256;
        logic [SIZE_W-1:0]  width_reg = 9'd256;
        logic [SIZE_W-1:0]  height_reg = 9'd256;
        bit                 hit_q [$];
        int                 errors = 0;
        int                 loads = 0;
        int                 ignored = 0;
        int                 queries = 0;
        int                 in_image = 0;
        int                 masked = 0;
        int                 checked = 0;

        // Size register forced into 1..most
        function int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned most);
            if (v == 0)
                return 1;
            return (v > most) ? most : v;
        endfunction

        // One axis: floor of (p - o) * inv in Q.12, valid when within 0..size-1
        function bit to_cell(logic [POINT_W-1:0] p, logic [POINT_W-1:0] o,
                             logic [SCALE_W-1:0] inv, int unsigned size,
                             output int unsigned idx);
            longint prod;
            prod = (longint'($signed(p)) - longint'($signed(o))) * longint'(inv);
            idx = 0;
            if (prod < 0)
                return 1'b0;
            if ((prod >>> FRAC_W) >= longint'(size))
                return 1'b0;
            idx = int'(prod >>> FRAC_W);
            return 1'b1;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_ORIGIN_X:     org_x = v[POINT_W-1:0];
                REG_ORIGIN_Y:     org_y = v[POINT_W-1:0];
                REG_INV_SCALE_X:  inv_x = v[SCALE_W-1:0];
                REG_INV_SCALE_Y:  inv_y = v[SCALE_W-1:0];
                REG_IMAGE_WIDTH:  width_reg = v[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: height_reg = v[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // Accepted input beat: advance the loader or queue the hit bit
        function void note_beat(op_t op, logic [ALPHA_W-1:0] alpha,
                                logic [POINT_W-1:0] px, logic [POINT_W-1:0] py);
            int unsigned w, h, col, row, addr;
            w = eff_size(width_reg, MAX_WIDTH);
            h = eff_size(height_reg, MAX_HEIGHT);
            if (op == OP_LOAD) begin
                if (loaded) begin
                    ignored++;
                    return;
                end
                loads++;
                if (load_col < MAX_WIDTH && load_row < MAX_HEIGHT) begin
                    addr = load_row * MAX_WIDTH + load_col;
                    mask_mem[addr] = (alpha > ALPHA_LIMIT);
                    written[addr] = 1'b1;
                end
                // row ends against the width in force now
                if (load_col + 1 >= w) begin
                    load_col = 0;
                    load_row++;
                    if (load_row >= h)
                        loaded = 1'b1;
                end else begin
                    load_col++;
                end
                return;
            end
            queries++;
            if (!loaded) begin
                hit_q.push_back(1'b1);
            end else if (to_cell(px, org_x, inv_x, w, col) &&
                         to_cell(py, org_y, inv_y, h, row)) begin
                in_image++;
                hit_q.push_back(mask_mem[row * MAX_WIDTH + col]);
            end else begin
                hit_q.push_back(1'b0);
            end
        endfunction

        // Accepted result beat against the oldest expectation
        function void check_beat(logic got);
            bit want;
            checked++;
            if (hit_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual is_masked=%b",
                         $time, got);
                return;
            end
            want = hit_q.pop_front();
            if (want)
                masked++;
            if (got !== want) begin
                errors++;
                $display("%0t: is_masked mismatch, expected %b, actual %b", $time, want, got);
            end
        endfunction

        // Columns written in every loaded row; bounds the width usable for reads
        function int unsigned safe_cols();
            int unsigned n, r, c;
            n = MAX_WIDTH;
            for (r = 0; r < load_row; r++) begin
                c = 0;
                while (c < MAX_WIDTH && written[r * MAX_WIDTH + c])
                    c++;
                if (c < n)
                    n = c;
            end
            return n;
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_TDATA_W-1:0]      s_tdata;   // alpha[7:0], point_x[27:8], point_y[47:28]
    logic [0:0]                 s_tuser;   // op[0]
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_TDATA_W-1:0]     m_tdata;   // is_masked[0], zero[7:1]
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    mask_scoreboard sb;
    bit             steady;
    int             cfg_count = 0;
    int             settings = 0;

    always #5 clk = ~clk;

    alpha_bitmask_hit_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Point coordinate aimed around the image span of one axis
    function automatic logic [POINT_W-1:0] aim(logic [POINT_W-1:0] o,
                                               logic [SCALE_W-1:0] inv, int unsigned size);
        longint span, d;
        int     r;
        span = (longint'(size) * 4096) / ((inv == 0) ? 64'sd1 : longint'(inv)) + 1;
        r = $urandom_range(0, 99);
        if (r < 80)
            d = $urandom_range(0, int'(span));
        else if (r < 90)
            d = -longint'($urandom_range(1, 64));
        else
            d = span + $urandom_range(0, 64);
        return POINT_W'(longint'($signed(o)) + d);
    endfunction

    task automatic send_beat(op_t op, logic [ALPHA_W-1:0] alpha,
                             logic [POINT_W-1:0] px, logic [POINT_W-1:0] py);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {py, px, alpha};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(op, alpha, px, py);
        gap = pick_gap(steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, v);
        cfg_count++;
    endtask

    task automatic set_geometry(logic [POINT_W-1:0] ox, logic [POINT_W-1:0] oy,
                                logic [SCALE_W-1:0] ix, logic [SCALE_W-1:0] iy,
                                logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
        write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
        write_reg(REG_INV_SCALE_X, CFG_DATA_W'(ix));
        write_reg(REG_INV_SCALE_Y, CFG_DATA_W'(iy));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Stop offering, let every result out, then let trailing loads retire
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.hit_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Mix of loads, full-range queries and queries aimed at the image
    task automatic run_phase(int n, int load_pct, int wide_pct);
        int          i, r;
        int unsigned w, h;
        for (i = 0; i < n; i++) begin
            w = sb.eff_size(sb.width_reg, MAX_WIDTH);
            h = sb.eff_size(sb.height_reg, MAX_HEIGHT);
            r = $urandom_range(0, 99);
            if (r < load_pct)
                send_beat(OP_LOAD, ALPHA_W'($urandom), '0, '0);
            else if (r < load_pct + wide_pct)
                send_beat(OP_QUERY, ALPHA_W'($urandom), POINT_W'($urandom),
                          POINT_W'($urandom));
            else
                send_beat(OP_QUERY, ALPHA_W'($urandom), aim(sb.org_x, sb.inv_x, w),
                          aim(sb.org_y, sb.inv_y, h));
        end
    endtask

    // Result side: random stalls in alternating calm and busy stretches, one long hold
    initial begin
        int stall;
        int mode_left;
        bit calm;
        bit held;
        stall = 0;
        mode_left = 0;
        calm = 1'b0;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata[0]);
            if (!held && sb.checked >= HOLD_AT) begin
                // long hold so the block fills and stalls its input
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    calm = ~calm;
                    mode_left = $urandom_range(100, 400);
                end
                mode_left--;
                if (stall > 0) begin
                    stall--;
                    m_tready <= 1'b0;
                end else begin
                    stall = pick_gap(calm);
                    m_tready <= (stall == 0);
                end
            end
        end
    end

    // Watchdog on cycles without any beat
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("alpha_bitmask_hit_test test failed");
        $finish;
    end

    // Stimulus
    initial begin
        int unsigned w1, w2, h2, sw, sh, r, c;
        int          p;
        logic [POINT_W-1:0] ox, oy;
        logic [SCALE_W-1:0] ix, iy;
        logic [SIZE_W-1:0]  w, h;

        sb = new();
        steady = 1'b1;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_LOAD;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ORIGIN_X;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sizes above range clamp to the maximum; queries before the load answer 1
        set_geometry('0, '0, 16'd256, 16'd256, 9'd511, 9'd300);
        send_beat(OP_QUERY, 8'hFF, 20'h7FFFF, 20'h7FFFF);
        send_beat(OP_QUERY, 8'h00, 20'h80000, 20'h80000);
        send_beat(OP_QUERY, 8'h5A, 20'h00000, 20'h00000);
        send_beat(OP_QUERY, 8'hA5, 20'h55555, 20'hAAAAA);
        send_beat(OP_LOAD, 8'd0, '0, '0);
        send_beat(OP_LOAD, 8'd127, 20'hFFFFF, 20'hFFFFF);
        send_beat(OP_LOAD, 8'd128, '0, '0);
        send_beat(OP_LOAD, 8'd255, '0, '0);
        steady = 1'b0;
        settle();

        // Load with one width, then shrink width and change height mid-load
        w1 = $urandom_range(12, 20);
        set_geometry('0, '0, 16'd256, 16'd256, SIZE_W'(w1), 9'd6);
        run_phase(40, 85, 0);
        settle();
        w2 = $urandom_range(5, w1 - 1);
        h2 = $urandom_range(3, 8);
        set_geometry('0, '0, 16'd256, 16'd256, SIZE_W'(w2), SIZE_W'(h2));
        while (!sb.loaded)
            run_phase(1, 85, 0);
        run_phase(10, 30, 0);
        settle();
        sw = sb.safe_cols();
        sh = sb.load_row;

        // One pixel per 16 Q16.4 units: edges just inside and just outside
        set_geometry('0, '0, 16'd256, 16'd256, SIZE_W'(sw), SIZE_W'(sh));
        send_beat(OP_QUERY, 8'h00, 20'd0, 20'd0);
        send_beat(OP_QUERY, 8'hFF, POINT_W'(sw * 16 - 1), POINT_W'(sh * 16 - 1));
        send_beat(OP_QUERY, 8'h00, POINT_W'(sw * 16), 20'd0);
        send_beat(OP_QUERY, 8'h00, 20'hFFFFF, 20'd0);
        send_beat(OP_QUERY, 8'h00, 20'd0, 20'hFFFFF);
        send_beat(OP_QUERY, 8'h00, 20'd0, POINT_W'(sh * 16));
        send_beat(OP_LOAD, 8'd255, '0, '0);
        send_beat(OP_LOAD, 8'd0, '0, '0);
        // every loaded cell once
        for (r = 0; r < sh; r++)
            for (c = 0; c < sw; c++)
                send_beat(OP_QUERY, ALPHA_W'($urandom),
                          POINT_W'(c * 16 + $urandom_range(0, 15)),
                          POINT_W'(r * 16 + $urandom_range(0, 15)));
        settle();

        // Zero inverse scale maps every point to cell 0
        set_geometry(POINT_W'($urandom), POINT_W'($urandom), 16'd0, 16'd0,
                     SIZE_W'(sw), SIZE_W'(sh));
        run_phase(20, 10, 30);
        settle();

        // Random settings, the extremes first
        for (p = 0; p < 10; p++) begin
            ox = ($urandom_range(0, 3) == 0) ? POINT_W'($urandom)
                                             : POINT_W'($signed($urandom_range(0, 16383)) - 8192);
            oy = ($urandom_range(0, 3) == 0) ? POINT_W'($urandom)
                                             : POINT_W'($signed($urandom_range(0, 16383)) - 8192);
            ix = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom_range(1, 65535))
                                             : SCALE_W'($urandom_range(32, 1024));
            iy = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom_range(1, 65535))
                                             : SCALE_W'($urandom_range(32, 1024));
            w = SIZE_W'($urandom_range(1, sw));
            h = SIZE_W'($urandom_range(1, sh));
            case (p)
                0: begin
                    ox = 20'h80000; oy = 20'h80000; ix = 16'd1; iy = 16'd1;
                    w = SIZE_W'(sw); h = SIZE_W'(sh);
                end
                1: begin
                    ox = 20'h7FFFF; oy = 20'h7FFFF; ix = 16'hFFFF; iy = 16'hFFFF;
                end
                2: begin
                    w = 9'd1; h = 9'd1;
                end
                3: begin
                    w = 9'd0; h = 9'd0;
                end
                4: begin
                    w = SIZE_W'(sw); h = SIZE_W'(sh);
                end
                default: ;
            endcase
            set_geometry(ox, oy, ix, iy, w, h);
            steady = ($urandom_range(0, 2) == 0);
            run_phase(120, 10, 10);
            steady = 1'b0;
            settle();
        end

        $display("Covered %0d loads (%0d ignored once full), %0d queries, ",
                 sb.loads, sb.ignored, sb.queries,
                 "%0d inside the image, %0d masked", sb.in_image, sb.masked);
        $display("%0d register writes over %0d settings, loaded mask %0d x %0d",
                 cfg_count, settings, sw, sh);
        if (sb.errors == 0)
            $display("alpha_bitmask_hit_test test passed");
        else
            $display("alpha_bitmask_hit_test test failed");
        $finish;
    end

endmodule
